FILE: rtl/core/ghra_pkg.sv
package ghra_pkg;

	// sizes fixed by the report format
	localparam int AXIS_NUM        = 6;
	localparam int BYTE_IDX_W      = 4;
	localparam int DEF_MAX_BUTTONS = 128;
	localparam int DEF_SPECIAL     = 8;
	localparam int DEF_QUEUE_DEPTH = 2;

	// operation codes
	localparam logic [2:0] OP_PRESS_BTN   = 3'd0;
	localparam logic [2:0] OP_RELEASE_BTN = 3'd1;
	localparam logic [2:0] OP_PRESS_SPC   = 3'd2;
	localparam logic [2:0] OP_RELEASE_SPC = 3'd3;
	localparam logic [2:0] OP_SET_AXES    = 3'd4;
	localparam logic [2:0] OP_SEND        = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_BUTTON_COUNT   = 2'd0;
	localparam logic [1:0] REG_SPECIAL_ENABLE = 2'd1;
	localparam logic [1:0] REG_AXIS_ENABLE    = 2'd2;
	localparam logic [1:0] REG_AUTO_REPORT    = 2'd3;

	// configuration reset values
	localparam logic [7:0] RST_BUTTON_COUNT   = 8'd16;
	localparam logic [7:0] RST_SPECIAL_ENABLE = 8'd0;
	localparam logic [5:0] RST_AXIS_ENABLE    = 6'h3f;
	localparam logic       RST_AUTO_REPORT    = 1'b1;

	// axis value that gets clamped, and its replacement
	localparam logic [15:0] AXIS_MIN_RAW = 16'h8000;
	localparam logic [15:0] AXIS_MIN_OK  = 16'h8001;

	// classified command from front to back
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_BTN_SET,
		CMD_BTN_CLR,
		CMD_SPC_SET,
		CMD_SPC_CLR,
		CMD_AXIS
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                          kind;
		logic [BYTE_IDX_W-1:0]              byte_idx;
		logic [7:0]                         bit_mask;
		logic [AXIS_NUM-1:0]                axis_mask;
		logic [AXIS_NUM-1:0][15:0]          axis_val;
		logic                               send;
	} cmd_t;

	// back end serializer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_BTN,
		BK_SPC,
		BK_AXIS
	} bk_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic busy;
		logic load;
	} bk_status_t;

	function automatic logic [15:0] clamp_axis(input logic [15:0] v);
		clamp_axis = (v == AXIS_MIN_RAW) ? AXIS_MIN_OK : v;
	endfunction

	// index of the lowest set bit, 0 when none
	function automatic logic [2:0] first_set(input logic [AXIS_NUM-1:0] bits);
		logic [2:0] idx;
		idx = 3'd0;
		for (int i = AXIS_NUM - 1; i >= 0; i--) begin
			if (bits[i]) begin
				idx = 3'(i);
			end
		end
		first_set = idx;
	endfunction

endpackage

FILE: rtl/core/ghra_front.sv
module ghra_front
	import ghra_pkg::*;
#(
	parameter int MAX_BUTTONS   = DEF_MAX_BUTTONS,
	parameter int SPECIAL_SLOTS = DEF_SPECIAL
) (
	input  logic        [2:0]  operation,
	input  logic        [7:0]  button_number,
	input  logic        [5:0]  axis_mask,
	input  logic signed [15:0] x_value,
	input  logic signed [15:0] y_value,
	input  logic signed [15:0] z_value,
	input  logic signed [15:0] rz_value,
	input  logic signed [15:0] rx_value,
	input  logic signed [15:0] ry_value,
	input  logic               connected,
	input  logic        [7:0]  special_enable,
	input  logic               auto_report,
	output cmd_t               cmd,
	output logic               useful
);

	logic [7:0] btn_off;
	logic [2:0] spc_pos;
	logic       change;
	logic       send;

	// special bit position: enabled slots below the slot, mod 8
	always_comb begin
		spc_pos = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (8'(i) < button_number && special_enable[i]) begin
				spc_pos = spc_pos + 3'd1;
			end
		end
	end

	// classify the item
	always_comb begin
		btn_off          = button_number - 8'd1;
		change           = 1'b0;
		send             = 1'b0;
		cmd.kind         = CMD_NONE;
		cmd.byte_idx     = btn_off[BYTE_IDX_W+2:3];
		cmd.bit_mask     = 8'd1 << btn_off[2:0];
		cmd.axis_mask    = axis_mask;
		cmd.axis_val[0]  = clamp_axis(x_value);
		cmd.axis_val[1]  = clamp_axis(y_value);
		cmd.axis_val[2]  = clamp_axis(z_value);
		cmd.axis_val[3]  = clamp_axis(rz_value);
		cmd.axis_val[4]  = clamp_axis(rx_value);
		cmd.axis_val[5]  = clamp_axis(ry_value);
		case (operation)
			OP_PRESS_BTN, OP_RELEASE_BTN: begin
				if (button_number != 8'd0 && button_number <= 8'(MAX_BUTTONS)) begin
					cmd.kind = (operation == OP_PRESS_BTN) ? CMD_BTN_SET : CMD_BTN_CLR;
					change   = 1'b1;
					send     = auto_report;
				end
			end
			OP_PRESS_SPC, OP_RELEASE_SPC: begin
				if (button_number < 8'(SPECIAL_SLOTS)) begin
					cmd.kind     = (operation == OP_PRESS_SPC) ? CMD_SPC_SET : CMD_SPC_CLR;
					cmd.bit_mask = 8'd1 << spc_pos;
					change       = 1'b1;
					send         = auto_report;
				end
			end
			OP_SET_AXES: begin
				cmd.kind = CMD_AXIS;
				change   = 1'b1;
				send     = auto_report;
			end
			OP_SEND: begin
				send = 1'b1;
			end
			default: begin
				change = 1'b0;
			end
		endcase
		cmd.send = send & connected;
		useful   = change | cmd.send;
	end

endmodule

FILE: rtl/core/ghra_cmd_queue.sv
module ghra_cmd_queue
	import ghra_pkg::*;
#(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: rtl/core/ghra_back.sv
module ghra_back
	import ghra_pkg::*;
#(
	parameter int MAX_BUTTONS = DEF_MAX_BUTTONS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] button_count,
	input  logic [7:0] special_enable,
	input  logic [5:0] axis_enable,
	input  cmd_t       cmd,
	input  logic       q_empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] report_byte,
	output logic       last_byte,
	output bk_status_t status
);

	localparam int BTN_BYTES = (MAX_BUTTONS + 7) / 8;
	localparam int BIDX_W    = (BTN_BYTES > 1) ? $clog2(BTN_BYTES) : 1;
	localparam int NB_W      = $clog2(BTN_BYTES + 1);

	logic [7:0]          btn_q [BTN_BYTES];
	logic [7:0]          spc_q;
	logic [15:0]         axis_q [AXIS_NUM];

	bk_state_t           state_q;
	bk_state_t           state_d;
	logic [BIDX_W-1:0]   btn_idx_q;
	logic [2:0]          axis_idx_q;
	logic                half_q;
	logic                out_valid_q;

	logic [7:0]          cnt_clamped;
	logic [8:0]          cnt_round;
	logic [NB_W-1:0]     nbtn;
	logic                spc_any;
	logic                axis_any;
	logic                btn_last;
	logic [AXIS_NUM-1:0] axis_rest;
	logic                axis_more;
	logic                out_load;
	logic                busy;
	logic [BIDX_W-1:0]   cmd_bidx;
	logic [7:0]          emit_byte;
	logic                emit_last;
	bk_state_t           start_state;

	// report shape from the configuration
	assign cnt_clamped = (button_count > 8'(MAX_BUTTONS)) ? 8'(MAX_BUTTONS) : button_count;
	assign cnt_round   = {1'b0, cnt_clamped} + 9'd7;
	assign nbtn        = NB_W'(cnt_round >> 3);
	assign spc_any     = (special_enable != 8'd0);
	assign axis_any    = (axis_enable != 6'd0);
	assign btn_last    = ((NB_W'(btn_idx_q) + NB_W'(1)) == nbtn);
	assign axis_rest   = axis_enable & ~((6'd2 << axis_idx_q) - 6'd1);
	assign axis_more   = (axis_rest != 6'd0);

	assign out_load = !out_valid_q || out_ready;
	assign busy     = (state_q != BK_IDLE);
	assign pop      = (state_q == BK_IDLE) && !q_empty;
	assign cmd_bidx = cmd.byte_idx[BIDX_W-1:0];

	assign start_state = (nbtn != '0) ? BK_BTN :
	                     spc_any      ? BK_SPC :
	                     axis_any     ? BK_AXIS : BK_IDLE;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (pop && cmd.send) begin
					state_d = start_state;
				end
			end
			BK_BTN: begin
				if (out_load && btn_last) begin
					state_d = spc_any ? BK_SPC : (axis_any ? BK_AXIS : BK_IDLE);
				end
			end
			BK_SPC: begin
				if (out_load) begin
					state_d = axis_any ? BK_AXIS : BK_IDLE;
				end
			end
			BK_AXIS: begin
				if (out_load && half_q && !axis_more) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// byte to emit and whether it closes the report
	always_comb begin
		emit_byte = 8'd0;
		emit_last = 1'b0;
		case (state_q)
			BK_BTN: begin
				emit_byte = btn_q[btn_idx_q];
				emit_last = btn_last && !spc_any && !axis_any;
			end
			BK_SPC: begin
				emit_byte = spc_q;
				emit_last = !axis_any;
			end
			BK_AXIS: begin
				emit_byte = half_q ? axis_q[axis_idx_q][15:8] : axis_q[axis_idx_q][7:0];
				emit_last = half_q && !axis_more;
			end
			default: begin
				emit_byte = 8'd0;
				emit_last = 1'b0;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			btn_idx_q  <= '0;
			axis_idx_q <= 3'd0;
			half_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				btn_idx_q  <= '0;
				axis_idx_q <= first_set(axis_enable);
				half_q     <= 1'b0;
			end else if (out_load && state_q == BK_BTN) begin
				btn_idx_q <= btn_idx_q + BIDX_W'(1);
			end else if (out_load && state_q == BK_AXIS) begin
				half_q <= !half_q;
				if (half_q) begin
					axis_idx_q <= first_set(axis_rest);
				end
			end
		end
	end

	// gamepad state, updated when a command is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BTN_BYTES; i++) begin
				btn_q[i] <= 8'd0;
			end
			spc_q <= 8'd0;
			for (int i = 0; i < AXIS_NUM; i++) begin
				axis_q[i] <= 16'd0;
			end
		end else if (pop) begin
			case (cmd.kind)
				CMD_BTN_SET: btn_q[cmd_bidx] <= btn_q[cmd_bidx] | cmd.bit_mask;
				CMD_BTN_CLR: btn_q[cmd_bidx] <= btn_q[cmd_bidx] & ~cmd.bit_mask;
				CMD_SPC_SET: spc_q <= spc_q | cmd.bit_mask;
				CMD_SPC_CLR: spc_q <= spc_q & ~cmd.bit_mask;
				CMD_AXIS: begin
					for (int i = 0; i < AXIS_NUM; i++) begin
						if (cmd.axis_mask[i]) begin
							axis_q[i] <= cmd.axis_val[i];
						end
					end
				end
				default: begin
					spc_q <= spc_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= busy;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && busy) begin
			report_byte <= emit_byte;
			last_byte   <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status.busy = busy;
	assign status.load = out_load && busy;

endmodule

FILE: rtl/core/gamepad_hid_report_assembler_unit.sv
// Gamepad HID input report assembler. Each input item is one event; the front end
// classifies it and queues a command unless it has no effect, the back end applies
// it to the button, special and axis state and, when a report is due, streams the
// report one byte per cycle while out_ready is high, with last_byte on its final
// byte. An event that sends nothing is applied while the back end is idle, so such
// items flow back to back; an event that sends a report holds the back end busy
// until every report byte (up to 29 bytes) is loaded into the single output register,
// while the two-entry command queue keeps accepting items until it fills, after which
// in_ready stays low until the back end takes the next command.
// Configuration is written through cfg_write/cfg_index/cfg_data and takes effect
// at once; write it only while no event is in flight.
module gamepad_hid_report_assembler_unit
	import ghra_pkg::*;
#(
	parameter int MAX_BUTTONS   = DEF_MAX_BUTTONS,
	parameter int SPECIAL_SLOTS = DEF_SPECIAL,
	parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic        [1:0]  cfg_index,
	input  logic        [7:0]  cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic        [2:0]  operation,
	input  logic        [7:0]  button_number,
	input  logic        [5:0]  axis_mask,
	input  logic signed [15:0] x_value,
	input  logic signed [15:0] y_value,
	input  logic signed [15:0] z_value,
	input  logic signed [15:0] rz_value,
	input  logic signed [15:0] rx_value,
	input  logic signed [15:0] ry_value,
	input  logic               connected,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [7:0]  report_byte,
	output logic               last_byte
);

	logic [7:0] button_count_q;
	logic [7:0] special_enable_q;
	logic [5:0] axis_enable_q;
	logic       auto_report_q;

	cmd_t       front_cmd;
	logic       front_useful;
	logic       cmd_push;
	cmd_t       head_cmd;
	q_status_t  q_stat;
	logic       cmd_pop;
	bk_status_t bk_stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_count_q   <= RST_BUTTON_COUNT;
			special_enable_q <= RST_SPECIAL_ENABLE;
			axis_enable_q    <= RST_AXIS_ENABLE;
			auto_report_q    <= RST_AUTO_REPORT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BUTTON_COUNT:   button_count_q   <= cfg_data;
				REG_SPECIAL_ENABLE: special_enable_q <= cfg_data;
				REG_AXIS_ENABLE:    axis_enable_q    <= cfg_data[5:0];
				REG_AUTO_REPORT:    auto_report_q    <= cfg_data[0];
				default:            auto_report_q    <= auto_report_q;
			endcase
		end
	end

	// front end: classify events
	ghra_front #(
		.MAX_BUTTONS   (MAX_BUTTONS),
		.SPECIAL_SLOTS (SPECIAL_SLOTS)
	) u_front (
		.operation      (operation),
		.button_number  (button_number),
		.axis_mask      (axis_mask),
		.x_value        (x_value),
		.y_value        (y_value),
		.z_value        (z_value),
		.rz_value       (rz_value),
		.rx_value       (rx_value),
		.ry_value       (ry_value),
		.connected      (connected),
		.special_enable (special_enable_q),
		.auto_report    (auto_report_q),
		.cmd            (front_cmd),
		.useful         (front_useful)
	);

	assign in_ready = !q_stat.full;
	assign cmd_push = in_valid && in_ready && front_useful;

	// command queue between front and back
	ghra_cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (front_cmd),
		.pop      (cmd_pop),
		.head     (head_cmd),
		.status   (q_stat)
	);

	// back end: state update and report serializer
	ghra_back #(
		.MAX_BUTTONS (MAX_BUTTONS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.button_count   (button_count_q),
		.special_enable (special_enable_q),
		.axis_enable    (axis_enable_q),
		.cmd            (head_cmd),
		.q_empty        (q_stat.empty),
		.pop            (cmd_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.report_byte    (report_byte),
		.last_byte      (last_byte),
		.status         (bk_stat)
	);

`ifndef SYNTHESIS
	// a command is never pushed into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !q_stat.full)
		else $error("command pushed into full queue");

	// the back end takes no command while it is streaming a report
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.busy |-> !cmd_pop)
		else $error("command taken during report");

	// a byte is loaded only while a report is being streamed
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.load |-> bk_stat.busy)
		else $error("output loaded while idle");
`endif

endmodule

FILE: sim/ghra_report_checker.sv
`timescale 1ns / 1ps

// watches both channels, keeps its own gamepad state and checks every report byte
module ghra_report_checker
	import ghra_pkg::*;
#(
	parameter int MAX_BUTTONS   = DEF_MAX_BUTTONS,
	parameter int SPECIAL_SLOTS = DEF_SPECIAL
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic        [1:0]  cfg_index,
	input  logic        [7:0]  cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic        [2:0]  operation,
	input  logic        [7:0]  button_number,
	input  logic        [5:0]  axis_mask,
	input  logic signed [15:0] x_value,
	input  logic signed [15:0] y_value,
	input  logic signed [15:0] z_value,
	input  logic signed [15:0] rz_value,
	input  logic signed [15:0] rx_value,
	input  logic signed [15:0] ry_value,
	input  logic               connected,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic        [7:0]  report_byte,
	input  logic               last_byte,
	output int                 errors,
	output int                 outstanding
);

	localparam int BTN_BYTES = (MAX_BUTTONS + 7) / 8;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} report_beat_t;

	report_beat_t report_q[$];
	report_beat_t oldest_beat;
	int           err_count = 0;

	// shadow of the gamepad state
	logic [7:0]  btn_map [BTN_BYTES];
	logic [7:0]  spc_byte;
	logic [15:0] axis_reg [AXIS_NUM];

	// shadow of the configuration
	logic [7:0] cnt_cfg;
	logic [7:0] spc_en_cfg;
	logic [5:0] axis_en_cfg;
	logic       auto_cfg;

	// bit of a special slot: number of enabled slots below it, wrapped to 3 bits
	function automatic logic [2:0] spc_bit_pos(input logic [7:0] en, input int slot);
		logic [2:0] pos;
		pos = '0;
		for (int i = 0; i < slot && i < 8; i++) begin
			if (en[i]) begin
				pos = pos + 3'd1;
			end
		end
		return pos;
	endfunction

	// append the bytes of one report to the expected stream
	task automatic queue_report();
		int nbytes;
		int added;
		added  = 0;
		nbytes = (cnt_cfg > MAX_BUTTONS) ? MAX_BUTTONS : int'(cnt_cfg);
		nbytes = (nbytes + 7) / 8;
		for (int i = 0; i < nbytes; i++) begin
			report_q.push_back('{btn_map[i], 1'b0});
			added++;
		end
		if (spc_en_cfg != 8'd0) begin
			report_q.push_back('{spc_byte, 1'b0});
			added++;
		end
		for (int a = 0; a < AXIS_NUM; a++) begin
			if (axis_en_cfg[a]) begin
				report_q.push_back('{axis_reg[a][7:0], 1'b0});
				report_q.push_back('{axis_reg[a][15:8], 1'b0});
				added += 2;
			end
		end
		if (added > 0) begin
			report_q[report_q.size() - 1].last = 1'b1;
		end
	endtask

	// apply one event to the shadow state and queue its report
	task automatic predict_event(input logic [2:0] op, input logic [7:0] num,
		input logic [5:0] mask, input logic [AXIS_NUM-1:0][15:0] vals, input logic conn);
		logic       do_send;
		logic [7:0] bm;
		int         n;
		do_send = 1'b0;
		n       = int'(num);
		case (op)
			OP_PRESS_BTN, OP_RELEASE_BTN: begin
				if (n >= 1 && n <= MAX_BUTTONS) begin
					bm = 8'(1 << ((n - 1) % 8));
					if (op == OP_PRESS_BTN) begin
						btn_map[(n - 1) / 8] = btn_map[(n - 1) / 8] | bm;
					end else begin
						btn_map[(n - 1) / 8] = btn_map[(n - 1) / 8] & ~bm;
					end
					do_send = auto_cfg;
				end
			end
			OP_PRESS_SPC, OP_RELEASE_SPC: begin
				if (n < SPECIAL_SLOTS && n < 8) begin
					bm = 8'(1 << spc_bit_pos(spc_en_cfg, n));
					if (op == OP_PRESS_SPC) begin
						spc_byte = spc_byte | bm;
					end else begin
						spc_byte = spc_byte & ~bm;
					end
					do_send = auto_cfg;
				end
			end
			OP_SET_AXES: begin
				// the most negative value is held one step up
				for (int a = 0; a < AXIS_NUM; a++) begin
					if (mask[a]) begin
						axis_reg[a] = (vals[a] == AXIS_MIN_RAW) ? AXIS_MIN_OK : vals[a];
					end
				end
				do_send = auto_cfg;
			end
			OP_SEND: begin
				do_send = 1'b1;
			end
			default: begin
			end
		endcase
		if (do_send && conn) begin
			queue_report();
		end
	endtask

	// register writes, output comparison, then prediction of the accepted item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (btn_map[i]) btn_map[i] = 8'd0;
			foreach (axis_reg[i]) axis_reg[i] = 16'd0;
			spc_byte    = 8'd0;
			cnt_cfg     = RST_BUTTON_COUNT;
			spc_en_cfg  = RST_SPECIAL_ENABLE;
			axis_en_cfg = RST_AXIS_ENABLE;
			auto_cfg    = RST_AUTO_REPORT;
			report_q.delete();
			outstanding <= 0;
			errors      <= err_count;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_BUTTON_COUNT:   cnt_cfg     = cfg_data;
					REG_SPECIAL_ENABLE: spc_en_cfg  = cfg_data;
					REG_AXIS_ENABLE:    axis_en_cfg = cfg_data[5:0];
					REG_AUTO_REPORT:    auto_cfg    = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				if (report_q.size() == 0) begin
					$error("report_byte %0h arrived with no report expected", report_byte);
					err_count++;
				end else begin
					oldest_beat = report_q.pop_front();
					if (report_byte !== oldest_beat.data) begin
						$error("report_byte mismatch: expected %0h, actual %0h",
							oldest_beat.data, report_byte);
						err_count++;
					end
					if (last_byte !== oldest_beat.last) begin
						$error("last_byte mismatch: expected %0b, actual %0b",
							oldest_beat.last, last_byte);
						err_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_event(operation, button_number, axis_mask,
					{ry_value, rx_value, rz_value, z_value, y_value, x_value}, connected);
			end
			outstanding <= report_q.size();
			errors      <= err_count;
		end
	end

endmodule

FILE: sim/tb_gamepad_hid_report_assembler_unit.sv
`timescale 1ns / 1ps

module tb_gamepad_hid_report_assembler_unit;
	import ghra_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 20;

	// codes the block treats as no operation
	localparam logic [2:0] OP_UNUSED_LO = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               cfg_write     = 1'b0;
	logic        [1:0]  cfg_index     = '0;
	logic        [7:0]  cfg_data      = '0;
	logic               in_valid      = 1'b0;
	logic        [2:0]  operation     = OP_SEND;
	logic        [7:0]  button_number = '0;
	logic        [5:0]  axis_mask     = '0;
	logic signed [15:0] x_value       = '0;
	logic signed [15:0] y_value       = '0;
	logic signed [15:0] z_value       = '0;
	logic signed [15:0] rz_value      = '0;
	logic signed [15:0] rx_value      = '0;
	logic signed [15:0] ry_value      = '0;
	logic               connected     = 1'b0;
	logic               out_ready     = 1'b0;
	logic               in_ready;
	logic               out_valid;
	logic        [7:0]  report_byte;
	logic               last_byte;

	int errors;
	int outstanding;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	gamepad_hid_report_assembler_unit u_top (.*);

	ghra_report_checker u_check (.*);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("gamepad_hid_report_assembler_unit verification failed");
			$finish;
		end
	end

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
			default: begin send_idle_pct = 11; recv_stall_pct = 11; end
		endcase
	endtask

	// present one event item and hold it until accepted
	task automatic drive_event(input logic [2:0] op, input logic [7:0] num,
		input logic [5:0] mask, input logic [5:0][15:0] vals, input logic conn);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		button_number <= num;
		axis_mask     <= mask;
		x_value       <= vals[0];
		y_value       <= vals[1];
		z_value       <= vals[2];
		rz_value      <= vals[3];
		rx_value      <= vals[4];
		ry_value      <= vals[5];
		connected     <= conn;
		do @(posedge clk); while (!in_ready);
	endtask

	// wait for every expected byte, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(input logic [7:0] bc, input logic [7:0] se,
		input logic [5:0] ae, input logic ar);
		cfg_write <= 1'b1;
		cfg_index <= REG_BUTTON_COUNT;
		cfg_data  <= bc;
		@(posedge clk);
		cfg_index <= REG_SPECIAL_ENABLE;
		cfg_data  <= se;
		@(posedge clk);
		cfg_index <= REG_AXIS_ENABLE;
		cfg_data  <= {2'b00, ae};
		@(posedge clk);
		cfg_index <= REG_AUTO_REPORT;
		cfg_data  <= {7'd0, ar};
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// one random event; counted is low for an unused code or an out-of-range button or slot
	task automatic random_event(output bit counted);
		int              pick;
		logic [2:0]      op;
		logic [7:0]      num;
		logic [5:0][15:0] vals;
		pick    = $urandom_range(0, 99);
		counted = 1'b1;
		num     = 8'($urandom_range(0, 255));
		if (pick < 30) begin
			op = pick[0] ? OP_RELEASE_BTN : OP_PRESS_BTN;
			if ($urandom_range(0, 99) < 85) begin
				num = 8'($urandom_range(1, 128));
			end
			counted = (num >= 8'd1 && num <= 8'd128);
		end else if (pick < 50) begin
			op = pick[0] ? OP_RELEASE_SPC : OP_PRESS_SPC;
			if ($urandom_range(0, 99) < 85) begin
				num = 8'($urandom_range(0, 7));
			end
			counted = (num < 8'd8);
		end else if (pick < 75) begin
			op = OP_SET_AXES;
		end else if (pick < 95) begin
			op = OP_SEND;
		end else begin
			op      = pick[0] ? OP_UNUSED_HI : OP_UNUSED_LO;
			counted = 1'b0;
		end
		// axis values lean toward the clamp point and the extremes
		for (int a = 0; a < 6; a++) begin
			case ($urandom_range(0, 9))
				0: vals[a] = AXIS_MIN_RAW;
				1: vals[a] = 16'h7fff;
				2: vals[a] = AXIS_MIN_OK;
				3: vals[a] = 16'h0000;
				default: vals[a] = 16'($urandom);
			endcase
		end
		drive_event(op, num, 6'($urandom_range(0, 63)), vals, $urandom_range(0, 9) != 0);
	endtask

	initial begin
		int done;
		bit counted;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed events under the reset settings
		set_idling(0);
		drive_event(OP_PRESS_BTN, 8'd1, '0, '0, 1'b1);
		drive_event(OP_PRESS_BTN, 8'd16, '0, '0, 1'b1);
		drive_event(OP_PRESS_BTN, 8'd128, '0, '0, 1'b1);
		drive_event(OP_PRESS_BTN, 8'd0, '0, '0, 1'b1);
		drive_event(OP_PRESS_BTN, 8'd129, '0, '0, 1'b1);
		drive_event(OP_RELEASE_BTN, 8'd1, '0, '0, 1'b1);
		drive_event(OP_PRESS_SPC, 8'd0, '0, '0, 1'b1);
		drive_event(OP_PRESS_SPC, 8'd7, '0, '0, 1'b1);
		drive_event(OP_PRESS_SPC, 8'd8, '0, '0, 1'b1);
		drive_event(OP_RELEASE_SPC, 8'd0, '0, '0, 1'b1);
		drive_event(OP_SET_AXES, 8'd0, 6'h3f,
			{16'h1234, 16'hffff, 16'h0000, AXIS_MIN_OK, 16'h7fff, AXIS_MIN_RAW}, 1'b1);
		drive_event(OP_SET_AXES, 8'd0, 6'h00, {6{16'h5555}}, 1'b1);
		drive_event(OP_SET_AXES, 8'd0, 6'h2a, {6{AXIS_MIN_RAW}}, 1'b1);
		drive_event(OP_SEND, 8'd0, '0, '0, 1'b1);
		drive_event(OP_SEND, 8'd0, '0, '0, 1'b0);
		drive_event(OP_PRESS_BTN, 8'd2, '0, '0, 1'b0);
		drive_event(OP_UNUSED_LO, 8'd3, 6'h3f, {6{16'hffff}}, 1'b1);
		drive_event(OP_UNUSED_HI, 8'd3, 6'h3f, {6{16'hffff}}, 1'b1);
		drain();

		// widest report, every special slot enabled
		apply_config(8'd128, 8'hff, 6'h3f, 1'b1);
		drive_event(OP_PRESS_BTN, 8'd128, '0, '0, 1'b1);
		drive_event(OP_PRESS_SPC, 8'd7, '0, '0, 1'b1);
		drive_event(OP_RELEASE_SPC, 8'd3, '0, '0, 1'b1);
		drive_event(OP_PRESS_BTN, 8'd255, '0, '0, 1'b1);
		drive_event(OP_SEND, 8'd0, '0, '0, 1'b1);
		drain();

		// empty report
		apply_config(8'd0, 8'h00, 6'h00, 1'b1);
		drive_event(OP_SEND, 8'd0, '0, '0, 1'b1);
		drive_event(OP_PRESS_BTN, 8'd5, '0, '0, 1'b1);
		drain();

		// random phases over several settings and idling patterns
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: apply_config(8'd128, 8'hff, 6'h3f, 1'b1);
				1: apply_config(8'd255, 8'ha5, 6'h15, 1'b1);
				2: apply_config(8'd9, 8'h80, 6'h3f, 1'b0);
				3: apply_config(8'd200, 8'h01, 6'h20, 1'b1);
				4: apply_config(8'd16, 8'h5a, 6'h3f, 1'b1);
				default: apply_config(8'($urandom_range(0, 255)), 8'($urandom),
					6'($urandom_range(0, 63)), 1'b1);
			endcase
			set_idling(p % 4);
			done = 0;
			while (done < PHASE_ITEMS) begin
				random_event(counted);
				if (counted) begin
					done++;
				end
			end
			drain();
		end

		if (errors == 0 && outstanding == 0) begin
			$display("gamepad_hid_report_assembler_unit verification clean");
		end else begin
			$display("gamepad_hid_report_assembler_unit verification failed");
		end
		$finish;
	end

endmodule
